/* sv/bqc_pkg.sv */
`timescale 1ns / 1ps
// Package for the biquad coefficient generator: fixed-point constants,
// elaboration-time table builders and the output saturation function. No dependencies.
package bqc_pkg;

  localparam int KNOB_BITS_DEF = 10;
  localparam int COEF_FRAC_DEF = 30;
  localparam int COEF_W        = 32;
  localparam int SIN_W         = 31;   // sine in [0, 2^30]
  localparam int Q_W           = 33;   // Q in Q30, up to 4.0
  localparam int ALPHA_W       = 30;   // alpha < 0.71 in Q30
  localparam int A0_W          = 31;   // 1 + alpha in Q30
  localparam int MAG_W         = 32;   // numerator magnitude, up to 2^31

  localparam logic [63:0] ONE_Q30        = 64'd1073741824;
  localparam logic [63:0] LOG2_RATIO_Q30 = 64'd10537467317;
  localparam logic [63:0] LN2_Q30        = 64'd744261118;
  localparam logic [63:0] OMEGA_MIN_Q40  = 64'd3454217652;
  localparam logic [63:0] OMEGA_MIN_Q30  = 64'd3373259;
  localparam logic [63:0] OMEGA_MAX_Q30  = 64'd3035933483;
  localparam logic [63:0] PI_Q30         = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
  localparam logic [63:0] Q_MIN_Q30      = 64'd759250125;
  localparam logic [63:0] Q_MAX_Q30      = 64'd4294967296;
  localparam logic [63:0] MASK_Q30       = 64'd1073741823;

  typedef struct packed {
    logic        [SIN_W-1:0]  sn;
    logic signed [COEF_W-1:0] cs;
  } trig_t;

  // truncating unsigned divide, shift and subtract; divisor below 2^63
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      quo = {quo[62:0], (rem >= b)};
      if (quo[0]) rem = rem - b;
    end
    return quo;
  endfunction

  // 2^f for f in [0,1) Q30, 14-term series, every term truncated
  function automatic logic [63:0] exp2_frac(logic [63:0] f);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] term;
    t    = (f * LN2_Q30) >> 30;
    sum  = ONE_Q30;
    term = ONE_Q30;
    for (int i = 1; i <= 13; i++) begin
      term = udiv64((term * t) >> 30, 64'(i));
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] omega_of_knob(logic [63:0] k, int kbits);
    logic [63:0] kmax;
    logic [63:0] y;
    logic [63:0] n;
    logic [63:0] p;
    logic [63:0] w;
    kmax = (64'd1 << kbits) - 64'd1;
    y    = udiv64(k * LOG2_RATIO_Q30 + (kmax >> 1), kmax);
    n    = (y >> 30) & 64'd15;
    p    = exp2_frac(y & MASK_Q30);
    w    = (OMEGA_MIN_Q40 * p) >> (64'd40 - n);
    if (w < OMEGA_MIN_Q30) w = OMEGA_MIN_Q30;
    if (w > OMEGA_MAX_Q30) w = OMEGA_MAX_Q30;
    return w;
  endfunction

  function automatic trig_t trig_of_knob(logic [63:0] k, int kbits);
    logic [63:0]        w;
    logic [63:0]        r;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] s;
    logic signed [63:0] c;
    logic               flip;
    trig_t              res;
    w    = omega_of_knob(k, kbits);
    r    = w;
    flip = 1'b0;
    if (w > HALF_PI_Q30) begin
      r    = PI_Q30 - w;
      flip = 1'b1;
    end
    ts = r;
    s  = $signed(r);
    tc = ONE_Q30;
    c  = $signed(ONE_Q30);
    for (int i = 1; i <= 10; i++) begin
      ts = udiv64((((ts * r) >> 30) * r) >> 30, 64'(2 * i) * 64'(2 * i + 1));
      tc = udiv64((((tc * r) >> 30) * r) >> 30, 64'(2 * i - 1) * 64'(2 * i));
      if ((i & 1) != 0) begin
        s = s - $signed(ts);
        c = c - $signed(tc);
      end else begin
        s = s + $signed(ts);
        c = c + $signed(tc);
      end
    end
    if (s < 0) s = 0;
    if (s > $signed(ONE_Q30)) s = $signed(ONE_Q30);
    if (c < -$signed(ONE_Q30)) c = -$signed(ONE_Q30);
    if (c > $signed(ONE_Q30)) c = $signed(ONE_Q30);
    res.sn = s[SIN_W-1:0];
    res.cs = flip ? COEF_W'(-c) : COEF_W'(c);
    return res;
  endfunction

  function automatic logic [Q_W-1:0] q_of_knob(logic [63:0] rk, int kbits);
    logic [63:0] kmax;
    logic [63:0] q;
    kmax = (64'd1 << kbits) - 64'd1;
    q    = Q_MIN_Q30 + udiv64(rk * (Q_MAX_Q30 - Q_MIN_Q30) + (kmax >> 1), kmax);
    return q[Q_W-1:0];
  endfunction

  // apply sign to a rounded magnitude, saturating to the 32-bit range
  function automatic logic [COEF_W-1:0] sat_coef(logic [COEF_W:0] v, logic neg);
    logic [COEF_W:0] m;
    if (neg) begin
      m = (v > 33'h080000000) ? 33'h080000000 : v;
      return 32'd0 - m[COEF_W-1:0];
    end
    m = (v > 33'h07FFFFFFF) ? 33'h07FFFFFFF : v;
    return m[COEF_W-1:0];
  endfunction

endpackage

/* sv/bqc_div_pipe.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Requires num >> QW < den. Depends on nothing.
module bqc_div_pipe #(
  parameter int NW = 61,
  parameter int DW = 34,
  parameter int QW = 30,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic          v_r    [QW+1];
  logic [DW-1:0] rem_r  [QW+1];
  logic [QW-1:0] lq_r   [QW+1];   // dividend bits shift out the top, quotient in
  logic [DW-1:0] den_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      rem_r[0]  <= DW'(num >> QW);
      lq_r[0]   <= num[QW-1:0];
      den_r[0]  <= den;
      side_r[0] <= side_in;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW+1:0] cat;
    logic [DW+1:0] diff;
    logic          ge;

    always_comb begin
      cat  = {1'b0, rem_r[s], lq_r[s][QW-1]};
      diff = cat - (DW+2)'(den_r[s]);
      ge   = !diff[DW+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
      if (en) begin
        rem_r[s+1]  <= ge ? diff[DW-1:0] : cat[DW-1:0];
        lq_r[s+1]   <= {lq_r[s][QW-2:0], ge};
        den_r[s+1]  <= den_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign quo       = lq_r[QW];
  assign side_out  = side_r[QW];

endmodule

/* sv/biquad_coefficient_generator_top.sv */
`timescale 1ns / 1ps
// Top level of the biquad coefficient generator (low-pass / high-pass).
// Depends on bqc_pkg and bqc_div_pipe.

// Turns a cutoff knob, a resonance knob and a pass-type flag into the five
// normalized biquad coefficients b0, b1, b2, a1, a2 in signed Q2.30 (the
// fraction width follows COEF_FRAC_BITS), saturated to the 32-bit range.
// Throughput is one beat per clock; the block is a fully pipelined datapath
// with a global stall, so a held output beat freezes the whole pipe and
// in_ready is high while out_valid is low or out_ready is high. The
// pipeline is, in order: the table-read register, 31 stages of the alpha
// divider, one numerator stage, COEF_FRAC_BITS + 3 stages of the four
// normalizing dividers running side by side, and the output register.
// Sine/cosine of the cutoff angle and Q of the resonance knob come from
// constant tables of 2^KNOB_BITS entries each, built at elaboration. The
// block holds no state between beats; reset only clears the valid bits.
module biquad_coefficient_generator_top #(
  parameter int KNOB_BITS      = bqc_pkg::KNOB_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqc_pkg::COEF_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [KNOB_BITS-1:0]              in_cutoff_knob,
  input  logic [KNOB_BITS-1:0]              in_resonance_knob,
  input  logic                              in_filter_highpass,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bqc_pkg::COEF_W-1:0] out_coef_b0,
  output logic signed [bqc_pkg::COEF_W-1:0] out_coef_b1,
  output logic signed [bqc_pkg::COEF_W-1:0] out_coef_b2,
  output logic signed [bqc_pkg::COEF_W-1:0] out_coef_a1,
  output logic signed [bqc_pkg::COEF_W-1:0] out_coef_a2
);

  import bqc_pkg::*;

  localparam int KNUM   = 1 << KNOB_BITS;
  localparam int AN_W   = SIN_W + 30;           // alpha dividend: sn * 2^30 + q
  localparam int AD_W   = Q_W + 1;              // alpha divisor: 2q
  localparam int AS_W   = COEF_W + 1;           // cos and the pass flag
  localparam int NN_W   = MAG_W + 1 + COEF_FRAC_BITS;
  localparam int NQ_W   = COEF_FRAC_BITS + 2;   // rounded magnitude, < 2^(F+2)

  // global stall: the whole pipe moves whenever the output slot frees up
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------------
  // constant tables, indexed by the knobs
  // ---------------------------------------------------------------------
  logic        [SIN_W-1:0]  sin_tab [KNUM];
  logic signed [COEF_W-1:0] cos_tab [KNUM];
  logic        [Q_W-1:0]    q_tab   [KNUM];

  for (genvar g = 0; g < KNUM; g++) begin : g_tab
    localparam trig_t          TRIG = trig_of_knob(64'(g), KNOB_BITS);
    localparam logic [Q_W-1:0] QV   = q_of_knob(64'(g), KNOB_BITS);
    assign sin_tab[g] = TRIG.sn;
    assign cos_tab[g] = TRIG.cs;
    assign q_tab[g]   = QV;
  end

  logic                     tv_r;
  logic        [SIN_W-1:0]  sn_r;
  logic signed [COEF_W-1:0] cs_r;
  logic        [Q_W-1:0]    q_r;
  logic                     hp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else if (en) begin
      tv_r <= in_valid;
    end
    if (en) begin
      sn_r <= sin_tab[in_cutoff_knob];
      cs_r <= cos_tab[in_cutoff_knob];
      q_r  <= q_tab[in_resonance_knob];
      hp_r <= in_filter_highpass;
    end
  end

  // ---------------------------------------------------------------------
  // alpha = round(sin / 2Q)
  // ---------------------------------------------------------------------
  logic [AN_W-1:0]    a_num;
  logic [AD_W-1:0]    a_den;
  logic               av;
  logic [ALPHA_W-1:0] alpha;
  logic [AS_W-1:0]    a_side;

  assign a_num = {sn_r, 30'd0} + AN_W'(q_r);
  assign a_den = {q_r, 1'b0};

  bqc_div_pipe #(.NW(AN_W), .DW(AD_W), .QW(ALPHA_W), .SW(AS_W)) u_alpha_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (tv_r),
    .num      (a_num),
    .den      (a_den),
    .side_in  ({hp_r, cs_r}),
    .out_valid(av),
    .quo      (alpha),
    .side_out (a_side)
  );

  // ---------------------------------------------------------------------
  // numerators as sign + magnitude, and a0
  // ---------------------------------------------------------------------
  logic signed [COEF_W-1:0] a_cs;
  logic                     a_hp;
  logic signed [COEF_W:0]   one_plus;
  logic signed [COEF_W:0]   one_minus;
  logic        [COEF_W-1:0] abs_cs;

  assign a_cs      = a_side[COEF_W-1:0];
  assign a_hp      = a_side[COEF_W];
  assign one_plus  = $signed((COEF_W+1)'(ONE_Q30)) + (COEF_W+1)'(a_cs);
  assign one_minus = $signed((COEF_W+1)'(ONE_Q30)) - (COEF_W+1)'(a_cs);
  assign abs_cs    = a_cs[COEF_W-1] ? COEF_W'(-a_cs) : a_cs;

  logic             nv_r;
  logic [A0_W-1:0]  a0_r;
  logic [MAG_W-1:0] mag_b0_r;
  logic [MAG_W-1:0] mag_b1_r;
  logic [MAG_W-1:0] mag_a1_r;
  logic [MAG_W-1:0] mag_a2_r;
  logic             neg_b1_r;
  logic             neg_a1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (en) begin
      nv_r <= av;
    end
    if (en) begin
      a0_r     <= A0_W'(ONE_Q30) + A0_W'(alpha);
      mag_b1_r <= a_hp ? one_plus[MAG_W-1:0] : one_minus[MAG_W-1:0];
      mag_b0_r <= a_hp ? one_plus[MAG_W:1] : one_minus[MAG_W:1];
      neg_b1_r <= a_hp;
      mag_a1_r <= {abs_cs[MAG_W-2:0], 1'b0};
      neg_a1_r <= !a_cs[COEF_W-1] && (a_cs != '0);
      mag_a2_r <= MAG_W'(ONE_Q30) - MAG_W'(alpha);
    end
  end

  // ---------------------------------------------------------------------
  // four normalizing dividers: round(|num| * 2^F / a0)
  // ---------------------------------------------------------------------
  logic [NN_W-1:0] half_a0;
  logic [NN_W-1:0] n_b0;
  logic [NN_W-1:0] n_b1;
  logic [NN_W-1:0] n_a1;
  logic [NN_W-1:0] n_a2;

  assign half_a0 = NN_W'(a0_r[A0_W-1:1]);
  assign n_b0    = (NN_W'(mag_b0_r) << COEF_FRAC_BITS) + half_a0;
  assign n_b1    = (NN_W'(mag_b1_r) << COEF_FRAC_BITS) + half_a0;
  assign n_a1    = (NN_W'(mag_a1_r) << COEF_FRAC_BITS) + half_a0;
  assign n_a2    = (NN_W'(mag_a2_r) << COEF_FRAC_BITS) + half_a0;

  logic            dv_b0, dv_b1, dv_a1, dv_a2;
  logic [NQ_W-1:0] q_b0, q_b1, q_a1, q_a2;
  logic            s_b0, s_b1, s_a1, s_a2;

  bqc_div_pipe #(.NW(NN_W), .DW(A0_W), .QW(NQ_W), .SW(1)) u_b0_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(nv_r),
    .num(n_b0), .den(a0_r), .side_in(1'b0),
    .out_valid(dv_b0), .quo(q_b0), .side_out(s_b0)
  );

  bqc_div_pipe #(.NW(NN_W), .DW(A0_W), .QW(NQ_W), .SW(1)) u_b1_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(nv_r),
    .num(n_b1), .den(a0_r), .side_in(neg_b1_r),
    .out_valid(dv_b1), .quo(q_b1), .side_out(s_b1)
  );

  bqc_div_pipe #(.NW(NN_W), .DW(A0_W), .QW(NQ_W), .SW(1)) u_a1_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(nv_r),
    .num(n_a1), .den(a0_r), .side_in(neg_a1_r),
    .out_valid(dv_a1), .quo(q_a1), .side_out(s_a1)
  );

  bqc_div_pipe #(.NW(NN_W), .DW(A0_W), .QW(NQ_W), .SW(1)) u_a2_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(nv_r),
    .num(n_a2), .den(a0_r), .side_in(1'b0),
    .out_valid(dv_a2), .quo(q_a2), .side_out(s_a2)
  );

  // ---------------------------------------------------------------------
  // sign, saturate, output register
  // ---------------------------------------------------------------------
  logic                     out_valid_r;
  logic signed [COEF_W-1:0] b0_r, b1_r, a1_r, a2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_b0 && dv_b1 && dv_a1 && dv_a2;
    end
    if (en) begin
      b0_r <= sat_coef((COEF_W+1)'(q_b0), s_b0);
      b1_r <= sat_coef((COEF_W+1)'(q_b1), s_b1);
      a1_r <= sat_coef((COEF_W+1)'(q_a1), s_a1);
      a2_r <= sat_coef((COEF_W+1)'(q_a2), s_a2);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_coef_b0 = b0_r;
  assign out_coef_b1 = b1_r;
  assign out_coef_b2 = b0_r;
  assign out_coef_a1 = a1_r;
  assign out_coef_a2 = a2_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_a0_range: assert property (@(posedge clk) disable iff (!rst_n)
    nv_r |-> (a0_r >= A0_W'(ONE_Q30)))
    else $error("a0 below one");

  a_b0_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !b0_r[COEF_W-1])
    else $error("b0 negative");

  a_a2_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!a2_r[COEF_W-1] && a2_r != '0))
    else $error("a2 not positive");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_b0 == dv_b1) && (dv_b0 == dv_a1) && (dv_b0 == dv_a2))
    else $error("divider valid bits out of step");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule
